// ===== rtl/core/slsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_pkg
// Shared widths, types and the quarter-wave sine entry function for the
// slew-limited sine generator.
// ----------------------------------------------------------------------------
package slsg_pkg;

  localparam int LEVEL_W = 16;
  localparam int SLEW_W  = 15;
  localparam int STEP_W  = 31;
  localparam int SINE_W  = 15;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam int          TAYLOR_N    = 12;

  // (2n)(2n+1) for n = 1 .. TAYLOR_N
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_N] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef struct packed {
    logic signed [LEVEL_W-1:0] dc;
    logic signed [LEVEL_W-1:0] ac;
  } lvl_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic o;
  } pipe_en_t;

  // One quarter-wave entry, unsigned Q0.15, from a Q30 Taylor series.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned tab_bits);
    logic        [63:0] x;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) >> tab_bits;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/slsg_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_sine_rom
// Quarter-wave sine ROM, 2^SINE_TABLE_BITS + 1 entries, registered read.
// ----------------------------------------------------------------------------
module slsg_sine_rom #(
  parameter int SINE_TABLE_BITS = slsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [SINE_TABLE_BITS:0]        rd_addr,
  output logic [slsg_pkg::SINE_W-1:0]     rd_data
);

  localparam int unsigned TAB_N = 1 << SINE_TABLE_BITS;

  typedef logic [slsg_pkg::SINE_W-1:0] rom_t [TAB_N+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k <= TAB_N; k++) begin
      r[k] = slsg_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [slsg_pkg::SINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/slsg_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_state
// Phase accumulator, slewed DC and AC levels and the slew step register.
// Presents the ROM address and levels held before each beat's update.
// ----------------------------------------------------------------------------
module slsg_state #(
  parameter int PHASE_BITS      = slsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = slsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [slsg_pkg::SLEW_W-1:0]         cfg_slew_step,
  input  logic                                accept,
  input  logic signed [slsg_pkg::LEVEL_W-1:0] dc_target,
  input  logic signed [slsg_pkg::LEVEL_W-1:0] ac_target,
  input  logic [slsg_pkg::STEP_W-1:0]         phase_step,
  output logic [SINE_TABLE_BITS:0]            rom_addr,
  output logic                                sine_neg,
  output slsg_pkg::lvl_t                      lvl
);

  localparam logic [SINE_TABLE_BITS:0] TAB_N = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;

  logic [PHASE_BITS-1:0]               phase_r, phase_nxt;
  logic signed [slsg_pkg::LEVEL_W-1:0] dc_r, dc_nxt;
  logic signed [slsg_pkg::LEVEL_W-1:0] ac_r, ac_nxt;
  logic [slsg_pkg::SLEW_W-1:0]         slew_r;
  logic [1:0]                          quad;
  logic [SINE_TABLE_BITS-1:0]          idx;

  function automatic logic signed [slsg_pkg::LEVEL_W-1:0] slew(
    input logic signed [slsg_pkg::LEVEL_W-1:0] cur,
    input logic signed [slsg_pkg::LEVEL_W-1:0] tgt,
    input logic        [slsg_pkg::SLEW_W-1:0]  stp
  );
    logic signed [slsg_pkg::LEVEL_W+1:0] diff;
    logic signed [slsg_pkg::LEVEL_W+1:0] s;
    logic signed [slsg_pkg::LEVEL_W+1:0] c;
    c    = (slsg_pkg::LEVEL_W+2)'(cur);
    diff = (slsg_pkg::LEVEL_W+2)'(tgt) - c;
    s    = signed'((slsg_pkg::LEVEL_W+2)'(stp));
    if (diff > 0) begin
      slew = (diff > s) ? slsg_pkg::LEVEL_W'(c + s) : tgt;
    end else begin
      slew = (-diff > s) ? slsg_pkg::LEVEL_W'(c - s) : tgt;
    end
  endfunction

  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign idx      = phase_r[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (TAB_N - {1'b0, idx}) : {1'b0, idx};
  assign sine_neg = quad[1];
  assign lvl.dc   = dc_r;
  assign lvl.ac   = ac_r;

  assign phase_nxt = phase_r + PHASE_BITS'(phase_step);
  assign dc_nxt    = slew(dc_r, dc_target, slew_r);
  assign ac_nxt    = slew(ac_r, ac_target, slew_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      dc_r    <= '0;
      ac_r    <= '0;
      slew_r  <= '0;
    end else begin
      if (cfg_we) begin
        slew_r <= cfg_slew_step;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        dc_r    <= dc_nxt;
        ac_r    <= ac_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/slsg_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_mix
// Signs the table value, multiplies by the AC level, rounds, adds the DC
// level and saturates to the sample width.
// ----------------------------------------------------------------------------
module slsg_mix #(
  parameter int SAMPLE_BITS = slsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  slsg_pkg::pipe_en_t              en,
  input  logic                            sine_neg,
  input  slsg_pkg::lvl_t                  lvl,
  input  logic [slsg_pkg::SINE_W-1:0]     rom_data,
  output logic signed [SAMPLE_BITS-1:0]   wave
);

  localparam int LW   = slsg_pkg::LEVEL_W;
  localparam int PW   = 2 * LW;
  localparam int SCW  = PW + 1 - 15;
  localparam int WW   = ((SAMPLE_BITS > SCW + 1) ? SAMPLE_BITS : SCW + 1) + 1;
  localparam logic signed [WW-1:0] SAT_HI = signed'(WW'({(SAMPLE_BITS-1){1'b1}}));
  localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

  logic                   neg1_r;
  logic signed [LW-1:0]   dc1_r, ac1_r;
  logic signed [LW-1:0]   sine1;
  logic signed [PW-1:0]   prod_nxt, prod2_r;
  logic signed [LW-1:0]   dc2_r;
  logic signed [PW:0]     rnd;
  logic signed [WW-1:0]   sum;
  logic signed [WW-1:0]   sat;
  logic signed [SAMPLE_BITS-1:0] wave_r;

  assign sine1    = neg1_r ? -signed'({1'b0, rom_data}) : signed'({1'b0, rom_data});
  assign prod_nxt = ac1_r * sine1;

  assign rnd = ((PW+1)'(prod2_r) + (PW+1)'(16384)) >>> 15;
  assign sum = WW'(dc2_r) + WW'(signed'(rnd[SCW-1:0]));

  always_comb begin
    sat = sum;
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1_r <= sine_neg;
      dc1_r  <= lvl.dc;
      ac1_r  <= lvl.ac;
    end
    if (en.s2) begin
      prod2_r <= prod_nxt;
      dc2_r   <= dc1_r;
    end
    if (en.o) begin
      wave_r <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign wave = wave_r;

endmodule

// ===== rtl/core/slew_limited_sine_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_limited_sine_generator
// Sine oscillator with slew-limited DC offset and AC amplitude.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    dc_target, ac_target, phase_step
//   out      source     out_valid/out_ready  wave_out
//   cfg      sink       cfg_valid/cfg_ready  slew_step
//
// One beat per cycle sustained while out_ready stays high; each result passes
// through the sine ROM read register, product register and output register.
// Phase and levels update in the accept cycle, so beats follow back to back.
// A stalled output holds its stage; empty stages ahead still take beats.
// Synchronous active-low reset clears state, slew step and stage valids.
// ----------------------------------------------------------------------------
module slew_limited_sine_generator #(
  parameter int PHASE_BITS      = slsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = slsg_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = slsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [slsg_pkg::LEVEL_W-1:0] in_dc_target,
  input  logic signed [slsg_pkg::LEVEL_W-1:0] in_ac_target,
  input  logic [slsg_pkg::STEP_W-1:0]         in_phase_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_wave_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slsg_pkg::SLEW_W-1:0]         cfg_slew_step
);

  slsg_pkg::pipe_en_t          en;
  slsg_pkg::lvl_t              lvl;
  logic [SINE_TABLE_BITS:0]    rom_addr;
  logic                        sine_neg;
  logic [slsg_pkg::SINE_W-1:0] rom_data;
  logic                        accept;
  logic                        v1_r, v2_r, vo_r;

  assign en.o   = !vo_r || out_ready;
  assign en.s2  = !v2_r || en.o;
  assign en.s1  = !v1_r || en.s2;
  assign accept = in_valid && en.s1;

  assign in_ready  = en.s1;
  assign out_valid = vo_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= in_valid;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.o) begin
        vo_r <= v2_r;
      end
    end
  end

  slsg_state #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_slew_step (cfg_slew_step),
    .accept        (accept),
    .dc_target     (in_dc_target),
    .ac_target     (in_ac_target),
    .phase_step    (in_phase_step),
    .rom_addr      (rom_addr),
    .sine_neg      (sine_neg),
    .lvl           (lvl)
  );

  slsg_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (en.s1),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  slsg_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk      (clk),
    .en       (en),
    .sine_neg (sine_neg),
    .lvl      (lvl),
    .rom_data (rom_data),
    .wave     (out_wave_out)
  );

endmodule

// ===== tb/tb_slew_limited_sine_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slew_limited_sine_generator
// Self-checking bench for the slew-limited sine generator. A queue-fed driver
// sends level targets and phase steps, and a clocked monitor predicts each
// sample from its own sine table, level slewing and phase accumulator. It then
// checks every output beat in order. Directed extremes come first (full-scale,
// frozen and unit slew steps, saturation, quadrant hops, phase wrap), then
// random runs of held targets under random slew settings and random idling on
// both channels, and a final random run with no idling.
// ----------------------------------------------------------------------------
module tb_slew_limited_sine_generator;

  localparam int LW             = slsg_pkg::LEVEL_W;
  localparam int SW             = slsg_pkg::SLEW_W;
  localparam int PW             = slsg_pkg::STEP_W;
  localparam int PHASE_W        = slsg_pkg::PHASE_BITS_DEF;
  localparam int TAB_BITS       = slsg_pkg::SINE_TABLE_BITS_DEF;
  localparam int WAVE_W         = slsg_pkg::SAMPLE_BITS_DEF;
  localparam int TAB_N          = 1 << TAB_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          WAVE_MAX    = (64'sd1 <<< (WAVE_W - 1)) - 1;
  localparam longint          WAVE_MIN    = -(64'sd1 <<< (WAVE_W - 1));

  typedef struct {
    logic signed [LW-1:0] dc;
    logic signed [LW-1:0] ac;
    logic [PW-1:0]        step;
  } tone_cmd_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic signed [LW-1:0]     in_dc_target  = '0;
  logic signed [LW-1:0]     in_ac_target  = '0;
  logic [PW-1:0]            in_phase_step = '0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic signed [WAVE_W-1:0] out_wave_out;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [SW-1:0]            cfg_slew_step = '0;

  tone_cmd_t                cmd_pending[$];
  tone_cmd_t                drv_cmd;
  logic signed [WAVE_W-1:0] wave_expected[$];
  logic signed [WAVE_W-1:0] wave_want;

  int            sine_q15 [0:TAB_N];
  logic [PHASE_W-1:0] phase_acc = '0;
  int            dc_lvl       = 0;
  int            ac_lvl       = 0;
  int            slew_cur     = 0;

  logic in_beat      = 1'b0;
  bit   calm         = 1'b0;
  int   in_idle_pct  = 0;
  int   out_idle_pct = 0;
  int   in_gap       = 0;
  int   out_gap      = 0;
  int   beats_queued = 0;
  int   waves_checked = 0;
  int   err_count    = 0;
  int   stall_cycles = 0;

  slew_limited_sine_generator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dc_target  (in_dc_target),
    .in_ac_target  (in_ac_target),
    .in_phase_step (in_phase_step),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_wave_out  (out_wave_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_slew_step (cfg_slew_step)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int quarter_wave_entry(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (HALF_PI_Q30 * longint'(k)) >> TAB_BITS;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return int'(v);
  endfunction

  function automatic logic signed [WAVE_W-1:0] predict_wave();
    logic [1:0]  quad;
    int unsigned idx;
    longint      s;
    longint      y;
    quad = phase_acc[PHASE_W-1 -: 2];
    idx  = 32'(phase_acc[PHASE_W-3 -: TAB_BITS]);
    s    = longint'(quad[0] ? sine_q15[TAB_N - idx] : sine_q15[idx]);
    if (quad[1]) begin
      s = -s;
    end
    y = longint'(dc_lvl) + ((longint'(ac_lvl) * s + 64'sd16384) >>> 15);
    if (y > WAVE_MAX) begin
      y = WAVE_MAX;
    end
    if (y < WAVE_MIN) begin
      y = WAVE_MIN;
    end
    return y[WAVE_W-1:0];
  endfunction

  function automatic int slew_toward(int level, int target, int step);
    int diff;
    diff = target - level;
    if (diff > 0) begin
      return (diff > step) ? level + step : target;
    end
    return (-diff > step) ? level - step : target;
  endfunction

  function automatic logic signed [LW-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return LW'($urandom);
    endcase
  endfunction

  function automatic logic [PW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return PW'($urandom_range(0, 1)) << (PHASE_W - 2);
      3:       return PW'($urandom_range(1, 65536)) << $urandom_range(0, 14);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  task automatic queue_cmd(input logic signed [LW-1:0] dc, input logic signed [LW-1:0] ac,
                           input logic [PW-1:0] step);
    tone_cmd_t c;
    c.dc   = dc;
    c.ac   = ac;
    c.step = step;
    cmd_pending.push_back(c);
    beats_queued++;
  endtask

  task automatic write_slew(input logic [SW-1:0] v);
    @(negedge clk);
    cfg_slew_step <= v;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (waves_checked != beats_queued) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_random_run(input int count);
    logic signed [LW-1:0] dc_t;
    logic signed [LW-1:0] ac_t;
    logic [PW-1:0]        run_step;
    dc_t     = '0;
    ac_t     = '0;
    run_step = '0;
    for (int i = 0; i < count; i++) begin
      if (i == 0 || $urandom_range(0, 9) == 0) begin
        dc_t     = pick_level();
        ac_t     = pick_level();
        run_step = pick_step();
      end
      queue_cmd(dc_t, ac_t, ($urandom_range(0, 3) == 0) ? pick_step() : run_step);
    end
  endtask

  // driver: input beats and output back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_beat) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_pending.size() != 0 && !calm &&
                     $urandom_range(0, 99) < in_idle_pct) begin
          in_gap   <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (cmd_pending.size() != 0) begin
          drv_cmd       = cmd_pending.pop_front();
          in_valid      <= 1'b1;
          in_dc_target  <= drv_cmd.dc;
          in_ac_target  <= drv_cmd.ac;
          in_phase_step <= drv_cmd.step;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap   <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat      <= 1'b0;
      stall_cycles = 0;
    end else begin
      in_beat <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        slew_cur = int'(cfg_slew_step);
      end
      if (in_valid && in_ready) begin
        wave_expected.push_back(predict_wave());
        dc_lvl    = slew_toward(dc_lvl, int'(in_dc_target), slew_cur);
        ac_lvl    = slew_toward(ac_lvl, int'(in_ac_target), slew_cur);
        phase_acc = phase_acc + PHASE_W'(in_phase_step);
      end
      if (out_valid && out_ready) begin
        if (wave_expected.size() == 0) begin
          report_mismatch($sformatf("wave_out %0d with no sample pending", out_wave_out));
        end else begin
          wave_want = wave_expected.pop_front();
          waves_checked++;
          if (out_wave_out !== wave_want) begin
            report_mismatch($sformatf("wave_out %0d, want %0d", out_wave_out, wave_want));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k <= TAB_N; k++) begin
      sine_q15[k] = quarter_wave_entry(k);
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-scale slew: extremes, saturation, quadrant hops and wrap
    in_idle_pct  = 20;
    out_idle_pct = 20;
    write_slew('1);
    queue_cmd(16'sh7FFF, 16'sh7FFF, '0);
    queue_cmd(16'sh7FFF, 16'sh7FFF, 31'h4000_0000);
    queue_cmd(16'sh7FFF, 16'sh7FFF, 31'h4000_0000);
    queue_cmd(16'sh7FFF, 16'sh7FFF, 31'h4000_0000);
    queue_cmd(16'sh8000, 16'sh8000, 31'h4000_0000);
    queue_cmd(16'sh8000, 16'sh8000, 31'h4000_0000);
    queue_cmd(16'sh8000, 16'sh8000, 31'h4000_0000);
    queue_cmd(16'sh8000, 16'sh7FFF, 31'h4000_0000);
    queue_cmd(16'sh8000, 16'sh7FFF, 31'h7FFF_FFFF);
    queue_cmd(16'sh0000, 16'sh7FFF, 31'h7FFF_FFFF);
    queue_cmd(16'sh0000, 16'sh8000, 31'h0010_0000);
    queue_cmd(16'sh0001, 16'shFFFF, 31'h5555_5555);
    queue_cmd(16'shFFFF, 16'sh0001, 31'h2AAA_AAAA);
    queue_cmd(16'sh0100, 16'sh0100, 31'h000F_FFFF);
    queue_cmd(16'sh0000, 16'sh0000, '0);
    settle();

    // zero slew: levels freeze whatever the targets
    write_slew('0);
    queue_cmd(16'sh7FFF, 16'sh8000, 31'h3FFF_FFFF);
    queue_cmd(16'sh8000, 16'sh7FFF, 31'h4000_0001);
    queue_cmd(16'sh1234, 16'shEDCB, 31'h7FFF_FFFF);
    settle();

    // unit slew: one LSB per tick, landing on near targets
    write_slew(15'd1);
    queue_cmd(16'sh0002, 16'shFFFE, 31'h0123_4567);
    queue_cmd(16'sh0002, 16'shFFFE, 31'h0123_4567);
    queue_cmd(16'sh0002, 16'shFFFE, 31'h0123_4567);
    queue_cmd(16'sh0001, 16'shFFFF, 31'h0123_4567);
    settle();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       write_slew('0);
        1:       write_slew(15'd1);
        2:       write_slew('1);
        3:       write_slew(SW'($urandom_range(2, 64)));
        4:       write_slew(SW'($urandom_range(256, 4096)));
        default: write_slew(SW'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       in_idle_pct = 0;
        1:       in_idle_pct = 10;
        2:       in_idle_pct = 30;
        default: in_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0:       out_idle_pct = 0;
        1:       out_idle_pct = 10;
        2:       out_idle_pct = 30;
        default: out_idle_pct = 60;
      endcase
      queue_random_run(42);
      settle();
    end

    calm = 1'b1;
    write_slew(SW'($urandom_range(1, 32767)));
    queue_random_run(40);
    settle();

    if (err_count == 0 && wave_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
